// ===== hdl/first_fit_free_list_allocator_macros.svh =====
// Assertion macros for the first-fit allocator checker.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
// implication checked on every clock edge outside reset
`define FFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/ffa_pkg.sv =====
// Package: types and codes for the first-fit allocator.
`default_nettype none
package ffa_pkg;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADREQ  = 2'd1;
	localparam logic [1:0] ST_OOM     = 2'd2;
	localparam logic [1:0] ST_BADFREE = 2'd3;
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;
	localparam logic [0:0] REG_MAX_REQUEST = 1'b0;
	localparam logic [0:0] REG_GROW_UNITS  = 1'b1;
	localparam logic [15:0] MAX_REQUEST_RST = 16'd4096;
	localparam logic [15:0] GROW_UNITS_RST  = 16'd1024;
	localparam logic [17:0] ALLOC_WALK_CAP = 18'd196612;
	localparam logic [17:0] FREE_WALK_CAP  = 18'd65537;
	typedef struct packed {
		logic [15:0] size;
		logic [15:0] next;
	} hdr_t;
endpackage
`default_nettype wire

// ===== hdl/ffa_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module ffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== hdl/first_fit_free_list_allocator.sv =====
// Top level: first-fit free-list heap allocator with a header RAM sequencer.
//  channel  | ports                                   | handshake
//  command  | command, request_bytes, block_address   | start & !busy
//  result   | status, address                         | done strobe, one cycle
//  config   | cfg_we, cfg_index, cfg_data             | cfg_we
// Each header read is issued in one cycle and used in the next (registered RAM read).
// Allocate: done pulses after a walk over the free list, one header read per entry
// visited, with a tail-header read and write for a split; a rejected request or a bad free skips it.
// Free: one walk of the list to the insert point, then block and next header reads and two writes.
// Each arena growth adds a header write and an insert walk. The free-list length sets the latency.
// Reset is asynchronous; the RAM is not cleared (headers undefined until written).
// The result cannot be stalled; busy drops in the cycle done pulses.
`default_nettype none
module first_fit_free_list_allocator
	import ffa_pkg::*;
#(
	parameter int HEAP_UNITS = 65536,
	parameter int UNIT_BYTES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         command,
	input  wire  [15:0] request_bytes,
	input  wire  [15:0] block_address,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] address,
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	// ceil division by UNIT_BYTES as a reciprocal multiply, exact for 17-bit numerators
	localparam int UB_K = 17 + $clog2(UNIT_BYTES);
	localparam logic [17:0] UB_RECIP =
		18'(((64'd1 << UB_K) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));
	localparam logic [16:0] LIMIT = (HEAP_UNITS < 65536) ? 17'(HEAP_UNITS) : 17'd65536;

	localparam logic [4:0] S_IDLE=5'd0, S_FCHK=5'd1, S_FCHKW=5'd2, S_INIT=5'd3,
		S_ARD=5'd4, S_ARDW=5'd5, S_PRD=5'd6, S_PRDW=5'd7, S_AEVAL=5'd8,
		S_ACUTW=5'd9, S_ACUT2=5'd10, S_GROW=5'd11, S_IRD=5'd12, S_IRDW=5'd13,
		S_IEVAL=5'd14, S_BRD=5'd15, S_BRDW=5'd16, S_NRD=5'd17, S_NRDW=5'd18,
		S_BWR=5'd19, S_PWR=5'd20, S_DONE=5'd21, S_APOST=5'd22, S_ANEXT=5'd23;

	logic [4:0] st_q;
	logic [15:0] max_req_q, grow_q, rover_q;
	logic started_q;
	logic [16:0] brk_q;
	logic cmd_q, ins_alloc_q;
	logic [15:0] nunits_q, prev_q, p_q, bp_q, ip_q;
	logic [17:0] steps_q, isteps_q;
	hdr_t h_q, ph_q, bh_q, nh_q;
	logic [1:0] stat_q;
	logic [15:0] addr_q;
	logic done_q;

	logic ram_we;
	logic [15:0] ram_a;
	hdr_t ram_wd, ram_rd;

	ffa_ram #(.WIDTH(32), .DEPTH(65536)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(ram_rd)
	);

	logic [16:0] ub_num;
	logic [34:0] ub_prod;
	logic [15:0] ru;
	logic [16:0] sum_bn, sum_pb;
	logic [15:0] nu, nx;
	logic [16:0] brk_sum;
	logic fits;
	always_comb begin
		ub_num = 17'(request_bytes) + 17'(UNIT_BYTES - 1);
		ub_prod = 35'(ub_num) * 35'(UB_RECIP);
		ru = 16'(ub_prod >> UB_K);
		nu = (nunits_q < grow_q) ? grow_q : nunits_q;
		brk_sum = brk_q + 17'(nu);
		nx = h_q.next;
		sum_bn = 17'(bp_q) + 17'(bh_q.size);
		sum_pb = 17'(ip_q) + 17'(ph_q.size);
		fits = ((bp_q > ip_q) && (bp_q < nx)) ||
			((ip_q >= nx) && ((bp_q > ip_q) || (bp_q < nx)));
	end

	always_comb begin
		ram_we = 1'b0;
		ram_a = '0;
		ram_wd = '0;
		case (st_q)
			S_FCHK: ram_a = bp_q;
			S_INIT: begin
				// sentinel at unit 0 is set up only by the first command that gets past its checks
				ram_we = !started_q;
			end
			S_ARD: ram_a = p_q;
			S_PRD: ram_a = prev_q;
			S_AEVAL: begin
				if (h_q.size == nunits_q) begin
					ram_we = 1'b1; ram_a = prev_q;
					ram_wd = {ph_q.size, h_q.next};
				end else if (h_q.size > nunits_q) begin
					ram_we = 1'b1; ram_a = p_q;
					ram_wd = {h_q.size - nunits_q, h_q.next};
				end
			end
			S_ACUTW: ram_a = p_q;
			S_ACUT2: begin
				// tail header keeps whatever next field it already held
				ram_we = 1'b1; ram_a = p_q;
				ram_wd = {nunits_q, ram_rd.next};
			end
			S_GROW: begin
				ram_we = (brk_sum <= LIMIT);
				ram_a = brk_q[15:0];
				ram_wd = {nu, 16'd0};
			end
			S_IRD: ram_a = ip_q;
			S_BRD: ram_a = bp_q;
			S_NRD: ram_a = h_q.next;
			S_BWR: begin
				ram_we = 1'b1; ram_a = bp_q;
				if (sum_bn == {1'b0, h_q.next})
					ram_wd = {bh_q.size + nh_q.size, nh_q.next};
				else
					ram_wd = {bh_q.size, h_q.next};
			end
			S_PWR: begin
				ram_we = 1'b1; ram_a = ip_q;
				if (sum_pb == {1'b0, bp_q})
					ram_wd = {ph_q.size + bh_q.size, bh_q.next};
				else
					ram_wd = {ph_q.size, bp_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			max_req_q <= MAX_REQUEST_RST;
			grow_q <= GROW_UNITS_RST;
			rover_q <= '0;
			started_q <= 1'b0;
			brk_q <= 17'd1;
			done_q <= 1'b0;
			cmd_q <= CMD_ALLOC;
			ins_alloc_q <= 1'b0;
			nunits_q <= '0;
			prev_q <= '0;
			p_q <= '0;
			bp_q <= '0;
			ip_q <= '0;
			steps_q <= '0;
			isteps_q <= '0;
			h_q <= '0;
			ph_q <= '0;
			bh_q <= '0;
			nh_q <= '0;
			stat_q <= ST_OK;
			addr_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_REQUEST: max_req_q <= cfg_data;
					REG_GROW_UNITS:  grow_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: if (start) begin
					cmd_q <= command;
					stat_q <= ST_OK;
					addr_q <= '0;
					steps_q <= '0;
					nunits_q <= ru + 16'd1;
					bp_q <= block_address - 16'd1;
					if (command == CMD_FREE) begin
						st_q <= S_FCHK;
					end else if (request_bytes == 16'd0 || request_bytes > max_req_q) begin
						stat_q <= ST_BADREQ;
						st_q <= S_DONE;
					end else begin
						st_q <= S_INIT;
					end
				end
				S_FCHK: st_q <= S_FCHKW;
				S_FCHKW: begin
					if (ram_rd.size == 16'd0 || ram_rd.size > max_req_q) begin
						stat_q <= ST_BADFREE;
						st_q <= S_DONE;
					end else begin
						st_q <= S_INIT;
					end
				end
				S_INIT: begin
					if (!started_q) begin
						started_q <= 1'b1;
						rover_q <= '0;
					end
					if (cmd_q == CMD_FREE) begin
						ins_alloc_q <= 1'b0;
						isteps_q <= '0;
						ip_q <= started_q ? rover_q : 16'd0;
						st_q <= S_IRD;
					end else begin
						prev_q <= started_q ? rover_q : 16'd0;
						st_q <= S_PRD;
					end
				end
				S_PRD: st_q <= S_PRDW;
				S_PRDW: begin
					ph_q <= ram_rd;
					p_q <= ram_rd.next;
					st_q <= S_ARD;
				end
				S_ARD: st_q <= S_ARDW;
				S_ARDW: begin
					h_q <= ram_rd;
					st_q <= S_AEVAL;
				end
				S_AEVAL: begin
					if (h_q.size >= nunits_q) begin
						rover_q <= prev_q;
						if (h_q.size == nunits_q) begin
							addr_q <= p_q + 16'd1;
							st_q <= S_DONE;
						end else begin
							p_q <= p_q + (h_q.size - nunits_q);
							st_q <= S_ACUTW;
						end
					end else if (p_q == rover_q) begin
						st_q <= S_GROW;
					end else begin
						st_q <= S_APOST;
					end
				end
				S_ACUTW: st_q <= S_ACUT2;
				S_ACUT2: begin
					h_q <= ram_rd;
					addr_q <= p_q + 16'd1;
					st_q <= S_DONE;
				end
				S_GROW: begin
					if (brk_sum > LIMIT) begin
						stat_q <= ST_OOM;
						st_q <= S_DONE;
					end else begin
						brk_q <= brk_sum;
						bp_q <= brk_q[15:0];
						ip_q <= rover_q;
						ins_alloc_q <= 1'b1;
						isteps_q <= '0;
						st_q <= S_IRD;
					end
				end
				S_APOST: begin
					prev_q <= p_q;
					ph_q <= h_q;
					p_q <= h_q.next;
					steps_q <= steps_q + 18'd1;
					if (steps_q + 18'd1 > ALLOC_WALK_CAP) begin
						stat_q <= ST_OOM;
						st_q <= S_DONE;
					end else begin
						st_q <= S_ARD;
					end
				end
				S_IRD: st_q <= S_IRDW;
				S_IRDW: begin
					h_q <= ram_rd;
					ph_q <= ram_rd;
					st_q <= S_IEVAL;
				end
				S_IEVAL: begin
					if (fits) begin
						st_q <= S_BRD;
					end else begin
						ip_q <= nx;
						isteps_q <= isteps_q + 18'd1;
						if (isteps_q + 18'd1 > FREE_WALK_CAP) begin
							stat_q <= ins_alloc_q ? ST_OOM : ST_BADFREE;
							st_q <= S_DONE;
						end else begin
							st_q <= S_IRD;
						end
					end
				end
				S_BRD: st_q <= S_BRDW;
				S_BRDW: begin
					bh_q <= ram_rd;
					st_q <= S_NRD;
				end
				S_NRD: st_q <= S_NRDW;
				S_NRDW: begin
					nh_q <= ram_rd;
					st_q <= S_BWR;
				end
				S_BWR: begin
					// bh_q takes the value just written so the prev merge sees it
					bh_q <= ram_wd;
					if (ip_q == bp_q) ph_q <= ram_wd;
					st_q <= S_PWR;
				end
				S_PWR: begin
					rover_q <= ip_q;
					if (ins_alloc_q) begin
						st_q <= S_ANEXT;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_ANEXT: begin
					// resume walk: prev = rover, p = next(prev) by a re-read
					prev_q <= rover_q;
					steps_q <= steps_q + 18'd1;
					if (steps_q + 18'd1 > ALLOC_WALK_CAP) begin
						stat_q <= ST_OOM;
						st_q <= S_DONE;
					end else begin
						st_q <= S_PRD;
					end
				end
				S_DONE: begin
					done_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign done = done_q;
	assign status = stat_q;
	assign address = addr_q;
endmodule
`default_nettype wire

// ===== hdl/ffa_checker.sv =====
// Port-level checker for the first-fit allocator, bound to the top level.
`default_nettype none
`include "first_fit_free_list_allocator_macros.svh"
module ffa_checker
	import ffa_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire [1:0]  status,
	input wire [15:0] address
);
	`FFA_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "no busy after start")
	`FFA_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy == 1'b0, "done while busy")
	`FFA_ASSERT_IMP(a_noaddr, clk, arst_n, done && status != ST_OK, address == '0, "addr on fail")
	`FFA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done longer than one cycle")
endmodule
bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .address(address)
);
`default_nettype wire

// ===== bench/first_fit_free_list_allocator_tb.sv =====
// Testbench for the first-fit free-list allocator: directed and random commands.
`timescale 1ns / 100ps
module first_fit_free_list_allocator_tb;
	import ffa_pkg::*;

	localparam int WATCHDOG_LIMIT = 600000;
	localparam int UNITS_PER_BYTE_ROUND = 16;
	localparam int HEAP_LIMIT = 65536;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] address;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        command = CMD_ALLOC;
	logic [15:0] request_bytes = '0;
	logic [15:0] block_address = '0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_MAX_REQUEST;
	logic [15:0] cfg_data = '0;
	wire         busy;
	wire         done;
	wire  [1:0]  status;
	wire  [15:0] address;

	first_fit_free_list_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .request_bytes(request_bytes), .block_address(block_address),
		.done(done), .status(status), .address(address),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// model state of the heap
	hdr_t        heap_hdr [HEAP_LIMIT];
	int unsigned rover_idx;
	bit          list_live;
	int unsigned brk;
	int unsigned max_req;
	int unsigned grow;

	outcome_t    pending_results [$];
	int unsigned live_blocks [$];
	int          errors = 0;
	int          idle_count = 0;
	int          stat_count [4] = '{0, 0, 0, 0};

	function automatic int unsigned hdr_next(int unsigned a);
		return heap_hdr[a & 16'hFFFF].next;
	endfunction

	function automatic int unsigned hdr_size(int unsigned a);
		return heap_hdr[a & 16'hFFFF].size;
	endfunction

	function automatic void put_next(int unsigned a, int unsigned n);
		heap_hdr[a & 16'hFFFF].next = n[15:0];
	endfunction

	function automatic void put_size(int unsigned a, int unsigned s);
		heap_hdr[a & 16'hFFFF].size = s[15:0];
	endfunction

	function automatic void open_list();
		if (!list_live) begin
			heap_hdr[0] = '0;
			rover_idx = 0;
			list_live = 1'b1;
		end
	endfunction

	// address-ordered insert with coalescing on both sides
	function automatic bit link_block(int unsigned bp_in);
		int unsigned p, nx, steps, bp;
		bp = bp_in & 16'hFFFF;
		p = rover_idx;
		steps = 0;
		forever begin
			nx = hdr_next(p);
			if (bp > p && bp < nx)
				break;
			if (p >= nx && (bp > p || bp < nx))
				break;
			p = nx;
			steps++;
			if (steps > FREE_WALK_CAP)
				return 1'b0;
		end
		nx = hdr_next(p);
		if (bp + hdr_size(bp) == nx) begin
			put_size(bp, hdr_size(bp) + hdr_size(nx));
			put_next(bp, hdr_next(nx));
		end else begin
			put_next(bp, nx);
		end
		if (p + hdr_size(p) == bp) begin
			put_size(p, hdr_size(p) + hdr_size(bp));
			put_next(p, hdr_next(bp));
		end else begin
			put_next(p, bp);
		end
		rover_idx = p;
		return 1'b1;
	endfunction

	function automatic outcome_t carve_block(int unsigned nbytes);
		outcome_t    r;
		int unsigned nunits, prv, p, sz, nu, steps;
		r.status = ST_OK;
		r.address = '0;
		if (nbytes < 1 || nbytes > max_req) begin
			r.status = ST_BADREQ;
			return r;
		end
		nunits = (nbytes + UNITS_PER_BYTE_ROUND - 1) / UNITS_PER_BYTE_ROUND + 1;
		open_list();
		prv = rover_idx;
		p = hdr_next(prv);
		steps = 0;
		forever begin
			sz = hdr_size(p);
			if (sz >= nunits) begin
				if (sz == nunits) begin
					put_next(prv, hdr_next(p));
				end else begin
					sz -= nunits;
					put_size(p, sz);
					p = (p + sz) & 16'hFFFF;
					put_size(p, nunits);
				end
				rover_idx = prv;
				r.address = (p + 1) & 16'hFFFF;
				return r;
			end
			if (p == rover_idx) begin
				nu = (nunits < grow) ? grow : nunits;
				if (brk + nu > HEAP_LIMIT) begin
					r.status = ST_OOM;
					return r;
				end
				heap_hdr[brk & 16'hFFFF] = {nu[15:0], 16'h0};
				brk = (brk + nu) & 17'h1FFFF;
				if (!link_block(brk - nu)) begin
					r.status = ST_OOM;
					return r;
				end
				p = rover_idx;
			end
			prv = p;
			p = hdr_next(p);
			steps++;
			if (steps > ALLOC_WALK_CAP) begin
				r.status = ST_OOM;
				return r;
			end
		end
	endfunction

	function automatic outcome_t release_block(int unsigned addr);
		outcome_t    r;
		int unsigned bp, sz;
		r.status = ST_OK;
		r.address = '0;
		bp = (addr - 1) & 16'hFFFF;
		sz = hdr_size(bp);
		if (sz < 1 || sz > max_req) begin
			r.status = ST_BADFREE;
			return r;
		end
		open_list();
		if (!link_block(bp))
			r.status = ST_BADFREE;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		outcome_t e;
		if (done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", status, -1);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status)
					report_mismatch("status", status, e.status);
				if (address !== e.address)
					report_mismatch("address", address, e.address);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count > WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	// one command transfer; predicts the result at the accepting edge
	task automatic send_command(input logic cmd, input int unsigned req,
			input int unsigned addr);
		outcome_t r;
		command <= cmd;
		request_bytes <= req[15:0];
		block_address <= addr[15:0];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (cmd == CMD_ALLOC) begin
			r = carve_block(req & 16'hFFFF);
			if (r.status == ST_OK)
				live_blocks.push_back(r.address);
		end else begin
			r = release_block(addr & 16'hFFFF);
		end
		stat_count[r.status]++;
		pending_results.push_back(r);
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			pause_sender(0);
		else if (r < 90)
			pause_sender($urandom_range(1, 4));
		else
			pause_sender($urandom_range(10, 60));
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input int unsigned val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_REQUEST)
			max_req = val & 16'hFFFF;
		else
			grow = val & 16'hFFFF;
	endtask

	task automatic alloc_bytes(input int unsigned n);
		send_command(CMD_ALLOC, n, $urandom_range(0, 65535));
	endtask

	// frees a random live block; drops it from the live set only when the free worked
	task automatic free_some_block();
		int          i;
		int unsigned a;
		i = $urandom_range(0, live_blocks.size() - 1);
		a = live_blocks[i];
		send_command(CMD_FREE, $urandom_range(0, 65535), a);
		if (pending_results[$].status == ST_OK)
			live_blocks.delete(i);
	endtask

	task automatic free_everything();
		while (live_blocks.size() != 0) begin
			free_some_block();
			random_gap();
		end
	endtask

	task automatic test_default_config();
		alloc_bytes(1);
		alloc_bytes(16);
		alloc_bytes(17);
		alloc_bytes(4096);
		alloc_bytes(0);
		alloc_bytes(4097);
		alloc_bytes(65535);
		free_some_block();
		free_some_block();
		alloc_bytes(100);
		free_everything();
	endtask

	task automatic test_size_extremes();
		int k;
		write_reg(REG_MAX_REQUEST, 65535);
		write_reg(REG_GROW_UNITS, 65535);
		alloc_bytes(65535);          // growth too big: out of memory
		write_reg(REG_GROW_UNITS, 1);
		for (k = 0; k < 17; k++)
			alloc_bytes(65535);      // grows by need until the arena is full
		free_everything();
		alloc_bytes(65535);
		write_reg(REG_MAX_REQUEST, 1);
		alloc_bytes(1);
		alloc_bytes(2);
		free_some_block();
		while (live_blocks.size() != 0) begin
			// bad header size: every live block stays allocated until the limit is raised
			free_some_block();
			if (live_blocks.size() != 0 && pending_results[$].status == ST_BADFREE)
				break;
		end
		write_reg(REG_MAX_REQUEST, 65535);
		free_everything();
	endtask

	task automatic random_phase(input int n, input int unsigned mr, input int unsigned gu);
		int          k, r;
		int unsigned top;
		write_reg(REG_MAX_REQUEST, mr);
		write_reg(REG_GROW_UNITS, gu);
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (live_blocks.size() != 0 && (r < 40 || live_blocks.size() > 60)) begin
				free_some_block();
			end else begin
				r = $urandom_range(0, 99);
				top = (max_req < 200) ? max_req : 200;
				if (r < 5)
					alloc_bytes(0);
				else if (r < 10)
					alloc_bytes((max_req < 65535) ? $urandom_range(max_req + 1, 65535)
						: $urandom_range(1, 65535));
				else if (r < 80)
					alloc_bytes($urandom_range(1, top));
				else
					alloc_bytes($urandom_range(1, max_req));
			end
			if (k < 40)
				pause_sender(0);    // back-to-back stretch
			else
				random_gap();
		end
		drain();                    // sender waits for every outstanding result
	endtask

	initial begin
		foreach (heap_hdr[i])
			heap_hdr[i] = '0;
		rover_idx = 0;
		list_live = 1'b0;
		brk = 1;
		max_req = MAX_REQUEST_RST;
		grow = GROW_UNITS_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_config();
		test_size_extremes();
		random_phase(270, 4096, 1024);
		random_phase(220, 300, 64);
		random_phase(270, 65535, 65535);
		free_everything();
		drain();
		$display("covered alloc/free with grow, split, merge and the four statuses:");
		$display("ok %0d, bad request %0d, out of memory %0d, bad free %0d",
			stat_count[ST_OK], stat_count[ST_BADREQ], stat_count[ST_OOM],
			stat_count[ST_BADFREE]);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
